FILE: hw/rtl/smagg_pkg.sv
// shared types and constants for the soil moisture aggregator
package smagg_pkg;

  localparam int unsigned ADC_W   = 12;
  localparam int unsigned HUM_W   = 15;
  localparam int unsigned PROD_W  = 27;
  localparam int unsigned STEPS   = HUM_W;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 16;

  localparam logic [HUM_W-1:0] FULL_SCALE = HUM_W'(25600);

  localparam logic [IDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [IDX_W-1:0] REG_DEFAULT_DRY = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEFAULT_WET = 2'd2;

  localparam logic [1:0] MODE_AVG = 2'd0;
  localparam logic [1:0] MODE_MIN = 2'd1;
  localparam logic [1:0] MODE_MAX = 2'd2;

  localparam logic [ADC_W-1:0] RESET_DRY = 12'd4095;
  localparam logic [ADC_W-1:0] RESET_WET = 12'd0;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_CHK  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

endpackage

FILE: hw/rtl/soil_moisture_aggregator_core.sv
// soil moisture aggregator: per-sample scaling and per-set average, minimum or maximum
// a divided sample runs prepare, scale, 15 divider steps, accumulate, set check, idle;
//   zero or full scale skips the divider steps, an ignored sample also scale and accumulate
// a closing sample adds a result state, after 15 more divider steps in average mode
// one shared restoring divider sets the rate; a waiting result stalls only a closing sample
// reset is asynchronous, active low; all set accumulators clear at reset and after each set
module soil_moisture_aggregator_core #(
  parameter int unsigned MAX_SENSORS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smagg_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [smagg_pkg::ADC_W-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // raw_sample[11:0], cal_dry[23:12], cal_wet[35:24], zero pad[39:36]
  input  logic [smagg_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  // present
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // humidity[14:0], zero pad[15]
  output logic [smagg_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  // result_valid
  output logic                             m_axis_tuser_o
);

  localparam int unsigned POS_W = $clog2(MAX_SENSORS + 1);
  localparam int unsigned SUM_W = smagg_pkg::HUM_W + POS_W;
  localparam int unsigned AW    = smagg_pkg::ADC_W;
  localparam int unsigned HW    = smagg_pkg::HUM_W;
  localparam int unsigned PW    = smagg_pkg::PROD_W;

  smagg_pkg::state_e state_q, state_d;

  logic [1:0]                  mode_q, mode_d;
  logic [AW-1:0]               def_dry_q, def_dry_d;
  logic [AW-1:0]               def_wet_q, def_wet_d;

  logic [AW-1:0]               raw_q, raw_d;
  logic [AW-1:0]               dry_q, dry_d;
  logic [AW-1:0]               wet_q, wet_d;
  logic                        present_q, present_d;
  logic                        last_q, last_d;
  logic                        zero_q, zero_d;
  logic                        avg_q, avg_d;

  logic [AW-1:0]               rem_q, rem_d;
  logic [HW-1:0]               low_q, low_d;
  logic [AW-1:0]               den_q, den_d;
  logic [AW-1:0]               num_q, num_d;
  logic [smagg_pkg::STEP_W-1:0] step_q, step_d;

  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [POS_W-1:0]            cnt_q, cnt_d;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic [HW-1:0]               min_q, min_d;
  logic [HW-1:0]               max_q, max_d;

  logic                        out_valid_q, out_valid_d;
  logic [HW-1:0]               out_hum_q, out_hum_d;
  logic                        out_rv_q, out_rv_d;

  logic [AW:0]                 trial;
  logic [AW:0]                 diff;
  logic                        ge;
  logic                        num_neg;
  logic                        den_neg;
  logic [PW-1:0]               prod;
  logic [PW-1:0]               sum_ext;
  logic                        take;
  logic                        res_valid;
  logic [AW-1:0]               in_dry;
  logic [AW-1:0]               in_wet;

  assign take     = s_axis_tvalid_i && s_axis_tready_o;
  assign trial    = {rem_q, low_q[HW-1]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = trial >= {1'b0, den_q};
  assign num_neg  = raw_q > dry_q;
  assign den_neg  = wet_q > dry_q;
  assign prod     = PW'(num_q) * PW'(smagg_pkg::FULL_SCALE);
  assign sum_ext  = PW'(sum_q);
  assign in_dry   = (s_axis_tdata_i[23:12] != '0) ? s_axis_tdata_i[23:12] : def_dry_q;
  assign in_wet   = (s_axis_tdata_i[35:24] != '0) ? s_axis_tdata_i[35:24] : def_wet_q;
  assign res_valid = (cnt_q != '0) &&
                     ((mode_q == smagg_pkg::MODE_AVG) || (mode_q == smagg_pkg::MODE_MIN) ||
                      (mode_q == smagg_pkg::MODE_MAX));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    def_dry_d   = def_dry_q;
    def_wet_d   = def_wet_q;
    raw_d       = raw_q;
    dry_d       = dry_q;
    wet_d       = wet_q;
    present_d   = present_q;
    last_d      = last_q;
    zero_d      = zero_q;
    avg_d       = avg_q;
    rem_d       = rem_q;
    low_d       = low_q;
    den_d       = den_q;
    num_d       = num_q;
    step_d      = step_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    min_d       = min_q;
    max_d       = max_q;
    out_valid_d = out_valid_q;
    out_hum_d   = out_hum_q;
    out_rv_d    = out_rv_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        smagg_pkg::REG_MODE:        mode_d    = cfg_data_i[1:0];
        smagg_pkg::REG_DEFAULT_DRY: def_dry_d = cfg_data_i;
        smagg_pkg::REG_DEFAULT_WET: def_wet_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      smagg_pkg::ST_IDLE: begin
        if (take) begin
          raw_d     = s_axis_tdata_i[11:0];
          dry_d     = in_dry;
          wet_d     = in_wet;
          present_d = s_axis_tuser_i;
          last_d    = s_axis_tlast_i;
          state_d   = smagg_pkg::ST_PREP;
        end
      end
      smagg_pkg::ST_PREP: begin
        num_d  = num_neg ? raw_q - dry_q : dry_q - raw_q;
        den_d  = den_neg ? wet_q - dry_q : dry_q - wet_q;
        zero_d = (raw_q == dry_q) || (num_neg != den_neg);
        avg_d  = 1'b0;
        if (pos_q < POS_W'(MAX_SENSORS)) begin
          pos_d = pos_q + POS_W'(1);
          if (present_q && (dry_q != wet_q)) begin
            state_d = smagg_pkg::ST_LOAD;
          end else begin
            state_d = smagg_pkg::ST_CHK;
          end
        end else begin
          state_d = smagg_pkg::ST_CHK;
        end
      end
      smagg_pkg::ST_LOAD: begin
        if (zero_q) begin
          low_d   = '0;
          state_d = smagg_pkg::ST_ACC;
        end else if (num_q >= den_q) begin
          low_d   = smagg_pkg::FULL_SCALE;
          state_d = smagg_pkg::ST_ACC;
        end else begin
          rem_d   = prod[PW-1:HW];
          low_d   = prod[HW-1:0];
          step_d  = '0;
          state_d = smagg_pkg::ST_DIV;
        end
      end
      smagg_pkg::ST_DIV: begin
        rem_d  = ge ? diff[AW-1:0] : trial[AW-1:0];
        low_d  = {low_q[HW-2:0], ge};
        step_d = step_q + smagg_pkg::STEP_W'(1);
        if (step_q == smagg_pkg::STEP_W'(smagg_pkg::STEPS - 1)) begin
          state_d = avg_q ? smagg_pkg::ST_FIN : smagg_pkg::ST_ACC;
        end
      end
      smagg_pkg::ST_ACC: begin
        sum_d = sum_q + SUM_W'(low_q);
        cnt_d = cnt_q + POS_W'(1);
        if (low_q < min_q) begin
          min_d = low_q;
        end
        if (low_q > max_q) begin
          max_d = low_q;
        end
        state_d = smagg_pkg::ST_CHK;
      end
      smagg_pkg::ST_CHK: begin
        if (!last_q) begin
          state_d = smagg_pkg::ST_IDLE;
        end else if ((cnt_q != '0) && (mode_q == smagg_pkg::MODE_AVG)) begin
          avg_d   = 1'b1;
          rem_d   = sum_ext[PW-1:HW];
          low_d   = sum_ext[HW-1:0];
          den_d   = AW'(cnt_q);
          step_d  = '0;
          state_d = smagg_pkg::ST_DIV;
        end else begin
          state_d = smagg_pkg::ST_FIN;
        end
      end
      smagg_pkg::ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_rv_d    = res_valid;
          if (!res_valid) begin
            out_hum_d = '0;
          end else if (mode_q == smagg_pkg::MODE_AVG) begin
            out_hum_d = low_q;
          end else if (mode_q == smagg_pkg::MODE_MIN) begin
            out_hum_d = min_q;
          end else begin
            out_hum_d = max_q;
          end
          sum_d   = '0;
          cnt_d   = '0;
          pos_d   = '0;
          min_d   = '1;
          max_d   = '0;
          state_d = smagg_pkg::ST_IDLE;
        end
      end
      default: state_d = smagg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smagg_pkg::ST_IDLE;
      mode_q      <= smagg_pkg::MODE_AVG;
      def_dry_q   <= smagg_pkg::RESET_DRY;
      def_wet_q   <= smagg_pkg::RESET_WET;
      step_q      <= '0;
      avg_q       <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      min_q       <= '1;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      def_dry_q   <= def_dry_d;
      def_wet_q   <= def_wet_d;
      step_q      <= step_d;
      avg_q       <= avg_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q     <= raw_d;
    dry_q     <= dry_d;
    wet_q     <= wet_d;
    present_q <= present_d;
    last_q    <= last_d;
    zero_q    <= zero_d;
    rem_q     <= rem_d;
    low_q     <= low_d;
    den_q     <= den_d;
    num_q     <= num_d;
    out_hum_q <= out_hum_d;
    out_rv_q  <= out_rv_d;
  end

  assign s_axis_tready_o = (state_q == smagg_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_hum_q};
  assign m_axis_tuser_o  = out_rv_q;

endmodule

FILE: hw/rtl/smagg_checker.sv
// port-level checks for the soil moisture aggregator and their binding
module smagg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [smagg_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  // not-valid results carry zero humidity
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("not-valid result with nonzero humidity");

  // humidity stays within full scale
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o <= smagg_pkg::M_DATA_W'(smagg_pkg::FULL_SCALE))
    else $error("humidity above full scale");

  // a request keeps the block busy in the following cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after a request");

  // a new result only comes out of the busy sequence
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result raised while idle");

endmodule

bind soil_moisture_aggregator_core smagg_checker u_smagg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: tb/tb_soil_moisture_aggregator_core.sv
// testbench for soil_moisture_aggregator_core: directed, pressure and random tests
module tb_soil_moisture_aggregator_core;

  localparam int unsigned SENSORS     = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 48;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [smagg_pkg::ADC_W-1:0] raw;
    logic                        present;
    logic [smagg_pkg::ADC_W-1:0] dry;
    logic [smagg_pkg::ADC_W-1:0] wet;
    logic                        last;
  } sample_t;

  typedef struct packed {
    logic [smagg_pkg::HUM_W-1:0] humidity;
    logic                        ok;
  } reading_t;

  logic                           clk_i;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [smagg_pkg::IDX_W-1:0]    cfg_idx_i       = '0;
  logic [smagg_pkg::ADC_W-1:0]    cfg_data_i      = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  // raw_sample[11:0], cal_dry[23:12], cal_wet[35:24], zero pad[39:36]
  logic [smagg_pkg::S_DATA_W-1:0] s_axis_tdata_i  = '0;
  // present
  logic                           s_axis_tuser_i  = 1'b0;
  logic                           s_axis_tlast_i  = 1'b0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  // humidity[14:0], zero pad[15]
  logic [smagg_pkg::M_DATA_W-1:0] m_axis_tdata_o;
  // result_valid
  logic                           m_axis_tuser_o;

  soil_moisture_aggregator_core #(.MAX_SENSORS(SENSORS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // predictor copy of registers and set accumulators
  logic [1:0]                  mode_q    = smagg_pkg::MODE_AVG;
  logic [smagg_pkg::ADC_W-1:0] dflt_dry  = smagg_pkg::RESET_DRY;
  logic [smagg_pkg::ADC_W-1:0] dflt_wet  = smagg_pkg::RESET_WET;
  int unsigned      set_sum   = 0;
  int unsigned      set_count = 0;
  int unsigned      set_min   = 32'hFFFF;
  int unsigned      set_max   = 0;
  int unsigned      set_pos   = 0;

  reading_t    reading_q[$];
  reading_t    got_reading;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_left    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (reading_q.size() == 0) begin
        $display("%0t unexpected result: humidity %0d valid %0b", $time,
                 m_axis_tdata_o[smagg_pkg::HUM_W-1:0], m_axis_tuser_o);
        error_count++;
      end else begin
        got_reading = reading_q.pop_front();
        if (m_axis_tdata_o[smagg_pkg::HUM_W-1:0] !== got_reading.humidity) begin
          $display("%0t humidity mismatch: expected %0d, actual %0d", $time,
                   got_reading.humidity, m_axis_tdata_o[smagg_pkg::HUM_W-1:0]);
          error_count++;
        end
        if (m_axis_tuser_o !== got_reading.ok) begin
          $display("%0t result_valid mismatch: expected %0b, actual %0b", $time,
                   got_reading.ok, m_axis_tuser_o);
          error_count++;
        end
      end
    end
  end

  function automatic int unsigned moisture_q88(logic [smagg_pkg::ADC_W-1:0] raw,
                                               logic [smagg_pkg::ADC_W-1:0] dry,
                                               logic [smagg_pkg::ADC_W-1:0] wet);
    logic        num_neg;
    logic        den_neg;
    int unsigned num;
    int unsigned den;
    int unsigned quo;
    num_neg = raw > dry;
    den_neg = wet > dry;
    num = num_neg ? int'(raw) - int'(dry) : int'(dry) - int'(raw);
    den = den_neg ? int'(wet) - int'(dry) : int'(dry) - int'(wet);
    if (num == 0 || num_neg != den_neg) return 0;
    quo = (int'(smagg_pkg::FULL_SCALE) * num) / den;
    return (quo > int'(smagg_pkg::FULL_SCALE)) ? int'(smagg_pkg::FULL_SCALE) : quo;
  endfunction

  task automatic update_moisture_set(input sample_t s);
    logic [smagg_pkg::ADC_W-1:0] dry;
    logic [smagg_pkg::ADC_W-1:0] wet;
    int unsigned                 pct;
    reading_t                    r;
    dry = (s.dry != 0) ? s.dry : dflt_dry;
    wet = (s.wet != 0) ? s.wet : dflt_wet;
    if (set_pos < SENSORS) begin
      if (s.present && dry != wet) begin
        pct = moisture_q88(s.raw, dry, wet);
        set_sum += pct;
        set_count++;
        if (pct < set_min) set_min = pct;
        if (pct > set_max) set_max = pct;
      end
      set_pos++;
    end
    if (s.last) begin
      r = '0;
      if (set_count != 0) begin
        case (mode_q)
          smagg_pkg::MODE_AVG:
            r = '{humidity: smagg_pkg::HUM_W'(set_sum / set_count), ok: 1'b1};
          smagg_pkg::MODE_MIN: r = '{humidity: smagg_pkg::HUM_W'(set_min), ok: 1'b1};
          smagg_pkg::MODE_MAX: r = '{humidity: smagg_pkg::HUM_W'(set_max), ok: 1'b1};
          default:  r = '0;
        endcase
      end
      reading_q.push_back(r);
      set_sum   = 0;
      set_count = 0;
      set_min   = 32'hFFFF;
      set_max   = 0;
      set_pos   = 0;
    end
  endtask

  function automatic sample_t mk_sample(int raw, bit present, int dry, int wet, bit last);
    return '{raw: smagg_pkg::ADC_W'(raw), present: present, dry: smagg_pkg::ADC_W'(dry),
             wet: smagg_pkg::ADC_W'(wet), last: last};
  endfunction

  // entered and left just after a falling edge
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, s.wet, s.dry, s.raw};
    s_axis_tuser_i  <= s.present;
    s_axis_tlast_i  <= s.last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    update_moisture_set(s);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [smagg_pkg::IDX_W-1:0] idx, input int value);
    s_axis_tvalid_i <= 1'b0;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= smagg_pkg::ADC_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      smagg_pkg::REG_MODE:        mode_q   = value[1:0];
      smagg_pkg::REG_DEFAULT_DRY: dflt_dry = smagg_pkg::ADC_W'(value);
      smagg_pkg::REG_DEFAULT_WET: dflt_wet = smagg_pkg::ADC_W'(value);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (reading_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic test_scaling_cases();
    send_sample(mk_sample(0,    1, 0,    0,    0));
    send_sample(mk_sample(4095, 1, 0,    0,    0));
    send_sample(mk_sample(2048, 0, 0,    0,    0));
    send_sample(mk_sample(100,  1, 2000, 2000, 0));
    // inverted calibration, above full scale and below zero
    send_sample(mk_sample(4000, 1, 100,  3000, 0));
    send_sample(mk_sample(50,   1, 100,  3000, 1));
    // nothing valid in the set
    send_sample(mk_sample(1234, 0, 0,    0,    0));
    send_sample(mk_sample(1234, 1, 4095, 4095, 1));
  endtask

  task automatic test_set_overflow();
    for (int i = 0; i < 10; i++)
      send_sample(mk_sample(i < SENSORS ? 4095 : 0, 1, 0, 0, i == 9));
  endtask

  task automatic test_modes();
    wait_idle();
    write_reg(smagg_pkg::REG_MODE, smagg_pkg::MODE_MIN);
    send_sample(mk_sample(1000, 1, 0, 0, 0));
    send_sample(mk_sample(3000, 1, 0, 0, 1));
    wait_idle();
    write_reg(smagg_pkg::REG_MODE, smagg_pkg::MODE_MAX);
    send_sample(mk_sample(1000, 1, 0, 0, 0));
    send_sample(mk_sample(3000, 1, 0, 0, 1));
    wait_idle();
    write_reg(smagg_pkg::REG_MODE, MODE_UNUSED);
    send_sample(mk_sample(1000, 1, 0, 0, 1));
    wait_idle();
    write_reg(smagg_pkg::REG_MODE, smagg_pkg::MODE_AVG);
  endtask

  function automatic sample_t random_sample(bit last);
    sample_t s;
    case ($urandom_range(9))
      0:       s.raw = '0;
      1:       s.raw = '1;
      default: s.raw = smagg_pkg::ADC_W'($urandom_range(4095));
    endcase
    s.present = ($urandom_range(99) < 85);
    s.dry     = ($urandom_range(99) < 30) ? '0 : smagg_pkg::ADC_W'($urandom_range(1, 4095));
    s.wet     = ($urandom_range(99) < 30) ? '0 : smagg_pkg::ADC_W'($urandom_range(1, 4095));
    if ($urandom_range(19) == 0) s.wet = s.dry;
    s.last = last;
    return s;
  endfunction

  task automatic send_random_set(output int unsigned n);
    n = ($urandom_range(99) < 85) ? $urandom_range(1, SENSORS) : $urandom_range(9, 12);
    for (int unsigned i = 0; i < n; i++)
      send_sample(random_sample(i == n - 1));
  endtask

  task automatic test_backpressure();
    wait_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 400;
    for (int i = 0; i < 24; i++)
      send_sample(random_sample(i % 2 == 1));
    wait_idle();
  endtask

  task automatic test_random_phases();
    int unsigned sent;
    int unsigned n;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase % 3)
        0:       write_reg(smagg_pkg::REG_MODE, smagg_pkg::MODE_AVG);
        1:       write_reg(smagg_pkg::REG_MODE, smagg_pkg::MODE_MIN);
        default: write_reg(smagg_pkg::REG_MODE, smagg_pkg::MODE_MAX);
      endcase
      case (phase)
        0: begin
          write_reg(smagg_pkg::REG_DEFAULT_DRY, 4095);
          write_reg(smagg_pkg::REG_DEFAULT_WET, 0);
        end
        1: begin
          write_reg(smagg_pkg::REG_DEFAULT_DRY, 0);
          write_reg(smagg_pkg::REG_DEFAULT_WET, 4095);
        end
        2: begin
          write_reg(smagg_pkg::REG_DEFAULT_DRY, 2000);
          write_reg(smagg_pkg::REG_DEFAULT_WET, 2000);
        end
        default: begin
          write_reg(smagg_pkg::REG_DEFAULT_DRY, $urandom_range(4095));
          write_reg(smagg_pkg::REG_DEFAULT_WET, $urandom_range(4095));
        end
      endcase
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      sent = 0;
      while (sent < 60) begin
        send_random_set(n);
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_scaling_cases();
    test_set_overflow();
    test_modes();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/smagg_pkg.sv
hw/rtl/soil_moisture_aggregator_core.sv
hw/rtl/smagg_checker.sv
tb/tb_soil_moisture_aggregator_core.sv
